// ===== design/utft_pkg.sv =====
// shared types and constants of the utf transcoder
package utft_pkg;

    localparam int UNIT_W      = 21;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 24;
    localparam int KIND_W      = 2;
    localparam int DIR_W       = 3;
    localparam int MAX_UNITS   = 4;
    localparam int CNT_W       = 3;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);

    // direction register codes
    localparam logic [DIR_W-1:0] DIR_U8_U16  = 3'd0;
    localparam logic [DIR_W-1:0] DIR_U8_U32  = 3'd1;
    localparam logic [DIR_W-1:0] DIR_U16_U8  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_U16_U32 = 3'd3;
    localparam logic [DIR_W-1:0] DIR_U32_U8  = 3'd4;
    localparam logic [DIR_W-1:0] DIR_U32_U16 = 3'd5;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_UNIT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_OK   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FAIL = 2'd2;

    localparam logic [UNIT_W-1:0] CP_MAX = 21'h10FFFF;

    // one queued job: destination units plus optional verdict
    typedef struct packed {
        logic [MAX_UNITS-1:0][UNIT_W-1:0] units;
        logic [CNT_W-1:0]                 cnt;
        logic                             eot;
        logic                             bad;
    } job_t;

endpackage

// ===== design/utft_front.sv =====
// front end: accepts source words, gathers sequences, decodes and encodes into jobs
module utft_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [utft_pkg::DIR_W-1:0]     cfg_wr_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [utft_pkg::IN_TDATA_W-1:0] s_tdata,
    input  logic                           s_tlast,
    input  logic                           q_full,
    output logic                           q_push,
    output utft_pkg::job_t                 q_job
);
    import utft_pkg::*;

    logic [DIR_W-1:0]  direction_reg;
    logic [23:0]       gathered_reg, gathered_next;
    logic [1:0]        expected_reg, expected_next;
    logic [1:0]        held_reg, held_next;
    logic [15:0]       high_sur_reg, high_sur_next;
    logic              sur_pend_reg, sur_pend_next;
    logic              err_reg, err_next;

    logic              accept;
    logic [7:0]        byte_in;
    logic [15:0]       u16_in;
    logic [31:0]       seq;
    logic [7:0]        b0, b1, b2, b3;
    logic              tails_ok, overlong, dec_ok;
    logic [UNIT_W-1:0] dec_cp;
    logic [UNIT_W-1:0] cp;
    logic              have;
    logic [19:0]       v;
    logic [MAX_UNITS-1:0][UNIT_W-1:0] units;
    logic [CNT_W-1:0]  cnt;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !q_full;
    assign byte_in  = s_tdata[7:0];
    assign u16_in   = s_tdata[15:0];
    assign seq      = {gathered_reg, byte_in};

    // utf-8 sequence decode of held bytes plus the current tail
    always_comb begin
        b0 = 8'h00;
        b1 = 8'h00;
        b2 = 8'h00;
        b3 = 8'h00;
        tails_ok = 1'b0;
        overlong = 1'b1;
        dec_cp   = '0;
        case (expected_reg)
            2'd1: begin
                b0 = seq[15:8];
                b1 = seq[7:0];
                tails_ok = (b1[7:6] == 2'b10);
                overlong = (b0[4:1] == 4'h0);
                dec_cp   = {10'b0, b0[4:0], b1[5:0]};
            end
            2'd2: begin
                b0 = seq[23:16];
                b1 = seq[15:8];
                b2 = seq[7:0];
                tails_ok = (b1[7:6] == 2'b10) && (b2[7:6] == 2'b10);
                overlong = (b0[3:0] == 4'h0) && !b1[5];
                dec_cp   = {5'b0, b0[3:0], b1[5:0], b2[5:0]};
            end
            2'd3: begin
                b0 = seq[31:24];
                b1 = seq[23:16];
                b2 = seq[15:8];
                b3 = seq[7:0];
                tails_ok = (b1[7:6] == 2'b10) && (b2[7:6] == 2'b10) && (b3[7:6] == 2'b10);
                overlong = (b0[2:0] == 3'h0) && (b1[5:4] == 2'b00);
                dec_cp   = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
            end
            default: begin
                tails_ok = 1'b0;
            end
        endcase
        dec_ok = tails_ok && !overlong && (dec_cp <= CP_MAX);
    end

    // stream state update
    always_comb begin
        gathered_next = gathered_reg;
        expected_next = expected_reg;
        held_next     = held_reg;
        high_sur_next = high_sur_reg;
        sur_pend_next = sur_pend_reg;
        err_next      = err_reg;
        cp            = '0;
        have          = 1'b0;
        if (!err_reg) begin
            unique case (direction_reg)
                DIR_U8_U16, DIR_U8_U32: begin
                    if (expected_reg == 2'd0) begin
                        if (!byte_in[7]) begin
                            cp   = {13'b0, byte_in};
                            have = 1'b1;
                        end else if (byte_in >= 8'hC2 && byte_in < 8'hF8) begin
                            expected_next = (byte_in < 8'hE0) ? 2'd1 :
                                            ((byte_in < 8'hF0) ? 2'd2 : 2'd3);
                            held_next     = 2'd1;
                            gathered_next = {16'h0, byte_in};
                        end else begin
                            err_next = 1'b1;
                        end
                    end else if (held_reg >= expected_reg) begin
                        gathered_next = '0;
                        expected_next = 2'd0;
                        held_next     = 2'd0;
                        if (dec_ok) begin
                            cp   = dec_cp;
                            have = 1'b1;
                        end else begin
                            err_next = 1'b1;
                        end
                    end else begin
                        gathered_next = seq[23:0];
                        held_next     = held_reg + 2'd1;
                    end
                end
                DIR_U16_U8, DIR_U16_U32: begin
                    if (sur_pend_reg) begin
                        if (u16_in[15:10] == 6'b110111) begin
                            cp   = 21'h10000 + {1'b0, high_sur_reg[9:0], u16_in[9:0]};
                            have = 1'b1;
                        end else if (u16_in == 16'h0000) begin
                            // lone high surrogate passes, the zero word is eaten
                            cp   = {5'b0, high_sur_reg};
                            have = 1'b1;
                        end else begin
                            err_next = 1'b1;
                        end
                        sur_pend_next = 1'b0;
                        high_sur_next = '0;
                    end else if (u16_in[15:10] == 6'b110110) begin
                        sur_pend_next = 1'b1;
                        high_sur_next = u16_in;
                    end else begin
                        cp   = {5'b0, u16_in};
                        have = 1'b1;
                    end
                end
                DIR_U32_U8, DIR_U32_U16: begin
                    if (s_tdata > {11'b0, CP_MAX}) begin
                        err_next = 1'b1;
                    end else begin
                        cp   = s_tdata[UNIT_W-1:0];
                        have = 1'b1;
                    end
                end
                default: begin
                    err_next = 1'b1;
                end
            endcase
        end
    end

    // encode the code point into destination words
    always_comb begin
        units = '0;
        cnt   = '0;
        v     = 20'(cp - 21'h10000);
        if (have) begin
            unique case (direction_reg)
                DIR_U16_U8, DIR_U32_U8: begin
                    if (cp < 21'h80) begin
                        units[0] = cp;
                        cnt      = (cp != '0) ? 3'd1 : 3'd0;
                    end else if (cp < 21'h800) begin
                        units[0] = {13'b0, 3'b110, cp[10:6]};
                        units[1] = {13'b0, 2'b10, cp[5:0]};
                        cnt      = 3'd2;
                    end else if (cp < 21'h10000) begin
                        units[0] = {13'b0, 4'b1110, cp[15:12]};
                        units[1] = {13'b0, 2'b10, cp[11:6]};
                        units[2] = {13'b0, 2'b10, cp[5:0]};
                        cnt      = 3'd3;
                    end else begin
                        units[0] = {13'b0, 5'b11110, cp[20:18]};
                        units[1] = {13'b0, 2'b10, cp[17:12]};
                        units[2] = {13'b0, 2'b10, cp[11:6]};
                        units[3] = {13'b0, 2'b10, cp[5:0]};
                        cnt      = 3'd4;
                    end
                end
                DIR_U8_U16, DIR_U32_U16: begin
                    if (cp < 21'h10000) begin
                        units[0] = cp;
                        // on utf-16 output a zero word survives only from utf-8 input
                        cnt = (cp != '0 || direction_reg == DIR_U8_U16) ? 3'd1 : 3'd0;
                    end else begin
                        units[0] = {5'b0, 6'b110110, v[19:10]};
                        units[1] = {5'b0, 6'b110111, v[9:0]};
                        cnt      = 3'd2;
                    end
                end
                DIR_U8_U32, DIR_U16_U32: begin
                    units[0] = cp;
                    cnt      = 3'd1;
                end
                default: begin
                    cnt = 3'd0;
                end
            endcase
        end
    end

    assign q_job.units = units;
    assign q_job.cnt   = cnt;
    assign q_job.eot   = s_tlast;
    assign q_job.bad   = err_next || sur_pend_next || (expected_next != 2'd0);
    assign q_push      = accept && ((cnt != '0) || s_tlast);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            direction_reg <= DIR_U8_U16;
            gathered_reg  <= '0;
            expected_reg  <= '0;
            held_reg      <= '0;
            high_sur_reg  <= '0;
            sur_pend_reg  <= 1'b0;
            err_reg       <= 1'b0;
        end else if (cfg_wr_en) begin
            direction_reg <= cfg_wr_data;
            gathered_reg  <= '0;
            expected_reg  <= '0;
            held_reg      <= '0;
            high_sur_reg  <= '0;
            sur_pend_reg  <= 1'b0;
            err_reg       <= 1'b0;
        end else if (accept) begin
            if (s_tlast) begin
                gathered_reg <= '0;
                expected_reg <= '0;
                held_reg     <= '0;
                high_sur_reg <= '0;
                sur_pend_reg <= 1'b0;
                err_reg      <= 1'b0;
            end else begin
                gathered_reg <= gathered_next;
                expected_reg <= expected_next;
                held_reg     <= held_next;
                high_sur_reg <= high_sur_next;
                sur_pend_reg <= sur_pend_next;
                err_reg      <= err_next;
            end
        end
    end

endmodule

// ===== design/utft_queue.sv =====
// job queue between front end and back end
module utft_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  utft_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output utft_pkg::job_t head,
    output logic           empty
);
    import utft_pkg::*;

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push, do_pop;

    assign full    = (count_reg == (QPTR_W+1)'(QDEPTH));
    assign empty   = (count_reg == '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== design/utft_back.sv =====
// back end: serializes queued jobs into output words through an output register
module utft_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  utft_pkg::job_t                   head,
    input  logic                             q_empty,
    output logic                             q_pop,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [utft_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic [utft_pkg::KIND_W-1:0]      m_tuser,
    output logic                             m_tlast
);
    import utft_pkg::*;

    logic                  valid_reg;
    logic [UNIT_W-1:0]     unit_reg;
    logic [KIND_W-1:0]     kind_reg;
    logic                  last_reg;
    logic [CNT_W-1:0]      idx_reg;

    logic                  load;
    logic [CNT_W-1:0]      total;
    logic                  word_last;
    logic [UNIT_W-1:0]     word_unit;
    logic [KIND_W-1:0]     word_kind;

    assign load      = !q_empty && (!valid_reg || m_tready);
    assign total     = head.cnt + {{(CNT_W-1){1'b0}}, head.eot};
    assign word_last = (idx_reg == total - 1'b1);
    assign q_pop     = load && word_last;

    // units first, then the verdict if the job ends the text
    always_comb begin
        if (idx_reg < head.cnt) begin
            word_unit = head.units[idx_reg[1:0]];
            word_kind = KIND_UNIT;
        end else begin
            word_unit = '0;
            word_kind = head.bad ? KIND_FAIL : KIND_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            unit_reg <= word_unit;
            kind_reg <= word_kind;
            last_reg <= word_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else if (load) begin
            valid_reg <= 1'b1;
            idx_reg   <= word_last ? '0 : idx_reg + 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{(OUT_TDATA_W-UNIT_W){1'b0}}, unit_reg};
    assign m_tuser  = kind_reg;
    assign m_tlast  = last_reg;

endmodule

// ===== design/utf_transcoder_core.sv =====
// top level of the utf-8 / utf-16 / utf-32 stream transcoder
//
// Write the direction through cfg_wr_en / cfg_wr_data while the block is idle;
// the write also clears all gathering and error state.
// Source words enter on s_tvalid / s_tready with the unit in s_tdata and
// end-of-text in s_tlast. Results leave on m_tvalid / m_tready: the unit in
// m_tdata, the kind (unit, success, failure) in m_tuser, and m_tlast on the
// final result caused by one source word.
// Throughput: one source word per cycle while the job queue has room. The back
// end emits one word per cycle while m_tready is high, so a source word that
// expands to k results (up to four units plus a verdict) holds the back end
// until all k are sent; a four-entry job queue absorbs short bursts before
// s_tready falls. The first result of a word reaches m_tvalid by way of the
// job queue and then the output register.
// Reset clears the direction to utf-8 to utf-16, the queue and the output
// register. When the receiver stalls the output word holds, the queue fills,
// and then s_tready drops until space opens.
module utf_transcoder_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [utft_pkg::DIR_W-1:0]       cfg_wr_data,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [utft_pkg::IN_TDATA_W-1:0]  s_tdata,     // [31:0] in_unit
    input  logic                             s_tlast,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [utft_pkg::OUT_TDATA_W-1:0] m_tdata,     // [20:0] out_unit, [23:21] zero
    output logic [utft_pkg::KIND_W-1:0]      m_tuser,     // [1:0] kind
    output logic                             m_tlast
);
    import utft_pkg::*;

    job_t push_job;
    job_t head;
    logic q_push, q_full, q_pop, q_empty;

    utft_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_job       (push_job)
    );

    utft_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .head     (head),
        .empty    (q_empty)
    );

    utft_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== design/utft_checker.sv =====
// port-level checks on the transcoder output channel, bound to the top level
module utft_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [utft_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic [utft_pkg::KIND_W-1:0]      m_tuser,
    input logic                             m_tlast
);
    import utft_pkg::*;

    // a stalled word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("output word changed while stalled");

    // a verdict always closes the run of its source word
    a_verdict_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_UNIT |-> m_tlast)
        else $error("verdict not marked last");

    // a verdict carries no unit
    a_verdict_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_UNIT |-> m_tdata == '0)
        else $error("verdict with nonzero data");

    // nothing shows right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !$past(aresetn) && aresetn |-> !m_tvalid)
        else $error("output valid just after reset");

endmodule

bind utf_transcoder_core utft_checker u_utft_checker (.*);

// ===== dv/utf_transcoder_core_tb.sv =====
// self-checking testbench for the utf-8 / utf-16 / utf-32 stream transcoder
`timescale 1ns / 100ps

module utf_transcoder_core_tb;
    import utft_pkg::*;

    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        logic [KIND_W-1:0] kind;
        logic              last;
    } out_word_t;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [DIR_W-1:0]       cfg_wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;     // [31:0] in_unit
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;     // [20:0] out_unit, [23:21] zero
    logic [KIND_W-1:0]      m_tuser;     // [1:0] kind
    logic                   m_tlast;

    // transcoder mirror state
    logic [DIR_W-1:0] dir_q;
    logic [23:0]      gath_q;
    logic [1:0]       need_q;
    logic [1:0]       held_q;
    logic [15:0]      hi_q;
    logic             sur_q;
    logic             err_q;

    out_word_t word_results[$];   // results of the word being predicted
    out_word_t due_out[$];        // results still to come from the block

    bit idle_on = 1'b1;
    int hold_cycles = 0;
    int mismatches = 0;
    int words_sent = 0;
    int results_seen = 0;
    int cfg_writes = 0;
    int strings_ok = 0;
    int strings_bad = 0;

    utf_transcoder_core i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    always #2 aclk = ~aclk;

    initial begin
        #400_000;
        $display("utf_transcoder_core_tb: errors");
        $finish;
    end

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t mismatch: %s", $time, what);
    endtask

    // ------------------------------------------------------------ predictor

    function automatic int utf8_len(input logic [UNIT_W-1:0] cp);
        if (cp < 21'h80) return 1;
        if (cp < 21'h800) return 2;
        if (cp < 21'h10000) return 3;
        return 4;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [UNIT_W-1:0] cp, input int n,
                                             input int idx);
        logic [UNIT_W-1:0] sh;
        if (n == 1) return cp[7:0];
        if (idx == 0) begin
            case (n)
                2: return {3'b110, cp[10:6]};
                3: return {4'b1110, cp[15:12]};
                default: return {5'b11110, cp[20:18]};
            endcase
        end
        sh = cp >> (6 * (n - 1 - idx));
        return {2'b10, sh[5:0]};
    endfunction

    // seq holds len bytes, lead byte highest
    function automatic logic utf8_seq_ok(input logic [31:0] seq, input int len,
                                         output logic [UNIT_W-1:0] cp);
        logic [7:0]  byt [4];
        logic [31:0] v;
        v = 32'h0;
        cp = '0;
        for (int i = 0; i < 4; i++) byt[i] = 8'h00;
        for (int i = 0; i < len; i++) byt[i] = seq[8 * (len - 1 - i) +: 8];
        for (int i = 1; i < len; i++) begin
            if (byt[i][7:6] != 2'b10) return 1'b0;
        end
        case (len)
            2: begin
                if (byt[0][4:1] == 4'h0) return 1'b0;
                v = {21'h0, byt[0][4:0], byt[1][5:0]};
            end
            3: begin
                if (byt[0][3:0] == 4'h0 && !byt[1][5]) return 1'b0;
                v = {16'h0, byt[0][3:0], byt[1][5:0], byt[2][5:0]};
            end
            4: begin
                if (byt[0][2:0] == 3'h0 && byt[1][5:4] == 2'h0) return 1'b0;
                v = {11'h0, byt[0][2:0], byt[1][5:0], byt[2][5:0], byt[3][5:0]};
            end
            default: return 1'b0;
        endcase
        cp = v[UNIT_W-1:0];
        return v <= 32'h10FFFF;
    endfunction

    task automatic clear_stream();
        gath_q = '0;
        need_q = '0;
        held_q = '0;
        hi_q   = '0;
        sur_q  = 1'b0;
        err_q  = 1'b0;
    endtask

    task automatic add_out(input logic [UNIT_W-1:0] u, input logic [KIND_W-1:0] k);
        out_word_t w;
        w.unit = u;
        w.kind = k;
        w.last = 1'b0;
        word_results.insert(word_results.size(), w);
    endtask

    task automatic emit_code_point(input logic [UNIT_W-1:0] cp);
        int n;
        logic [UNIT_W-1:0] v;
        case (dir_q)
            DIR_U16_U8, DIR_U32_U8: begin
                // zero code point is dropped on utf-8 output
                if (cp != '0) begin
                    n = utf8_len(cp);
                    for (int i = 0; i < n; i++) add_out(utf8_byte(cp, n, i), KIND_UNIT);
                end
            end
            DIR_U8_U16, DIR_U32_U16: begin
                if (cp < 21'h10000) begin
                    if (cp != '0 || dir_q == DIR_U8_U16) add_out(cp, KIND_UNIT);
                end else begin
                    v = cp - 21'h10000;
                    add_out(21'hD800 + v[20:10], KIND_UNIT);
                    add_out(21'hDC00 + v[9:0], KIND_UNIT);
                end
            end
            default: add_out(cp, KIND_UNIT);
        endcase
    endtask

    // advance the mirror by one accepted word and queue what it yields
    task automatic transcode_word(input logic [31:0] unit, input logic eot);
        logic [7:0]        b;
        logic [15:0]       u;
        logic [UNIT_W-1:0] cp;
        logic [31:0]       seq;
        logic              have;
        logic              bad;
        int                len;
        word_results.delete();
        have = 1'b0;
        cp = '0;
        if (!err_q) begin
            case (dir_q)
                DIR_U8_U16, DIR_U8_U32: begin
                    b = unit[7:0];
                    if (need_q == 2'd0) begin
                        if (b < 8'h80) begin
                            cp = {13'h0, b};
                            have = 1'b1;
                        end else if (b >= 8'hC2 && b < 8'hF8) begin
                            need_q = (b < 8'hE0) ? 2'd1 : ((b < 8'hF0) ? 2'd2 : 2'd3);
                            held_q = 2'd1;
                            gath_q = {16'h0, b};
                        end else begin
                            err_q = 1'b1;
                        end
                    end else if (held_q >= need_q) begin
                        seq = {gath_q, b};
                        len = need_q + 1;
                        gath_q = '0;
                        need_q = '0;
                        held_q = '0;
                        if (utf8_seq_ok(seq, len, cp)) have = 1'b1;
                        else err_q = 1'b1;
                    end else begin
                        gath_q = {gath_q[15:0], b};
                        held_q = held_q + 2'd1;
                    end
                end
                DIR_U16_U8, DIR_U16_U32: begin
                    u = unit[15:0];
                    if (sur_q) begin
                        if (u >= 16'hDC00 && u < 16'hE000) begin
                            cp = 21'h10000 + {1'b0, hi_q[9:0], u[9:0]};
                            have = 1'b1;
                        end else if (u == 16'h0) begin
                            // zero after a high surrogate lets the surrogate through
                            cp = {5'h0, hi_q};
                            have = 1'b1;
                        end else begin
                            err_q = 1'b1;
                        end
                        sur_q = 1'b0;
                        hi_q = '0;
                    end else if (u >= 16'hD800 && u < 16'hDC00) begin
                        sur_q = 1'b1;
                        hi_q = u;
                    end else begin
                        cp = {5'h0, u};
                        have = 1'b1;
                    end
                end
                DIR_U32_U8, DIR_U32_U16: begin
                    if (unit > 32'h10FFFF) begin
                        err_q = 1'b1;
                    end else begin
                        cp = unit[UNIT_W-1:0];
                        have = 1'b1;
                    end
                end
                default: err_q = 1'b1;
            endcase
            if (have && !err_q) emit_code_point(cp);
        end
        if (eot) begin
            bad = err_q || sur_q || need_q != 2'd0;
            add_out('0, bad ? KIND_FAIL : KIND_OK);
            if (bad) strings_bad++;
            else strings_ok++;
            clear_stream();
        end
        if (word_results.size() > 0) word_results[word_results.size() - 1].last = 1'b1;
        foreach (word_results[i]) due_out.insert(due_out.size(), word_results[i]);
    endtask

    // ------------------------------------------------------------ checker

    always @(posedge aclk) begin : check_out
        out_word_t w;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (due_out.size() == 0) begin
                report_mismatch($sformatf("unexpected word data=%h kind=%0d last=%b",
                                          m_tdata, m_tuser, m_tlast));
            end else begin
                w = due_out.pop_front();
                if (m_tdata !== {3'b000, w.unit})
                    report_mismatch($sformatf("unit %h, want %h", m_tdata, w.unit));
                if (m_tuser !== w.kind)
                    report_mismatch($sformatf("kind %0d, want %0d", m_tuser, w.kind));
                if (m_tlast !== w.last)
                    report_mismatch($sformatf("tlast %b, want %b", m_tlast, w.last));
            end
        end
    end

    // receiver: short random stalls, or one long hold-off on request
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        m_tready = 1'b1;
        forever begin
            @(negedge aclk);
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (hold_cycles > 0) begin
                stall_left = hold_cycles - 1;
                hold_cycles = 0;
                m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(0, 3);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------ stimulus

    // called and returns at a falling edge
    task automatic send_word(input logic [31:0] unit, input logic eot);
        s_tvalid <= 1'b1;
        s_tdata  <= unit;
        s_tlast  <= eot;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        transcode_word(unit, eot);
        words_sent++;
        @(negedge aclk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
    endtask

    // stop sending and let every pending word and silent job clear out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (due_out.size() != 0) @(negedge aclk);
        repeat (10) @(negedge aclk);
    endtask

    task automatic set_direction(input logic [DIR_W-1:0] d);
        drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= d;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        dir_q = d;
        clear_stream();
        cfg_writes++;
    endtask

    function automatic logic [UNIT_W-1:0] pick_code_point();
        case ($urandom_range(0, 9))
            0: return '0;
            1, 2: return UNIT_W'($urandom_range(21'h1, 21'h7F));
            3: return UNIT_W'($urandom_range(21'h80, 21'h7FF));
            4, 5: return UNIT_W'($urandom_range(21'h800, 21'hFFFF));
            6: return UNIT_W'($urandom_range(21'hD800, 21'hDFFF));
            7, 8: return UNIT_W'($urandom_range(21'h10000, 21'h10FFFF));
            default: begin
                case ($urandom_range(0, 6))
                    0: return 21'h7F;
                    1: return 21'h80;
                    2: return 21'h7FF;
                    3: return 21'h800;
                    4: return 21'hFFFF;
                    5: return 21'h10000;
                    default: return 21'h10FFFF;
                endcase
            end
        endcase
    endfunction

    // a string of code points (surrogate values included) in the source encoding, maybe damaged
    task automatic send_text(input int n_cp, input bit noisy, input bit close);
        logic [31:0]       src_units[$];
        logic [31:0]       w;
        logic [UNIT_W-1:0] cp;
        int                n;
        int                idx;
        for (int k = 0; k < n_cp; k++) begin
            cp = pick_code_point();
            case (dir_q)
                DIR_U8_U16, DIR_U8_U32: begin
                    n = utf8_len(cp);
                    for (int i = 0; i < n; i++)
                        src_units.insert(src_units.size(), {24'h0, utf8_byte(cp, n, i)});
                end
                DIR_U16_U8, DIR_U16_U32: begin
                    if (cp < 21'h10000) begin
                        src_units.insert(src_units.size(), {11'h0, cp});
                    end else begin
                        src_units.insert(src_units.size(),
                                         32'hD800 + ((cp - 21'h10000) >> 10));
                        src_units.insert(src_units.size(), 32'hDC00 + cp[9:0]);
                    end
                end
                default: src_units.insert(src_units.size(), {11'h0, cp});
            endcase
        end
        if (noisy) begin
            idx = $urandom_range(0, src_units.size() - 1);
            case ($urandom_range(0, 3))
                0: src_units[idx] = $urandom;
                1: src_units.insert(idx, $urandom);
                2: if (src_units.size() > 1) void'(src_units.pop_back());
                default: src_units[idx][7:0] = 8'($urandom_range(8'h80, 8'hFF));
            endcase
        end
        foreach (src_units[i]) begin
            w = src_units[i];
            // bits above the source unit are don't-care
            if ($urandom_range(0, 3) == 0) begin
                if (dir_q == DIR_U8_U16 || dir_q == DIR_U8_U32) w[31:8] = 24'($urandom);
                else if (dir_q == DIR_U16_U8 || dir_q == DIR_U16_U32) w[31:16] = 16'($urandom);
            end
            send_word(w, close && i == src_units.size() - 1);
        end
    endtask

    task automatic random_phase(input logic [DIR_W-1:0] d, input int n_words);
        int start;
        set_direction(d);
        start = words_sent;
        while (words_sent - start < n_words) begin
            send_text($urandom_range(1, 6), $urandom_range(0, 4) == 0, $urandom_range(0, 7) != 0);
        end
    endtask

    // ------------------------------------------------------------ tests

    task automatic test_directed();
        set_direction(DIR_U8_U16);
        // zero byte, top code point, top two-byte value
        send_word(32'h00, 1'b0);
        send_word(32'hF4, 1'b0);
        send_word(32'h8F, 1'b0);
        send_word(32'hBF, 1'b0);
        send_word(32'hBF, 1'b0);
        send_word(32'hDF, 1'b0);
        send_word(32'hBF, 1'b1);
        // decodes above the code space limit
        send_word(32'hF4, 1'b0);
        send_word(32'h90, 1'b0);
        send_word(32'h80, 1'b0);
        send_word(32'h80, 1'b1);
        // bad lead, following byte suppressed
        send_word(32'hC1, 1'b0);
        send_word(32'h41, 1'b1);

        set_direction(DIR_U8_U32);
        // overlong three-byte form
        send_word(32'hE0, 1'b0);
        send_word(32'h9F, 1'b0);
        send_word(32'hBF, 1'b1);
        // truncated sequence
        send_word(32'hE0, 1'b0);
        send_word(32'hA0, 1'b1);

        set_direction(DIR_U16_U8);
        // pair, high surrogate then zero, lone low, zero unit
        send_word(32'hD83D, 1'b0);
        send_word(32'hDE00, 1'b0);
        send_word(32'hDBFF, 1'b0);
        send_word(32'h0000, 1'b0);
        send_word(32'hDC00, 1'b0);
        send_word(32'h0000, 1'b1);
        // high surrogate followed by a plain unit
        send_word(32'hD800, 1'b0);
        send_word(32'h0041, 1'b1);

        set_direction(DIR_U32_U8);
        send_word(32'h0010_FFFF, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h0011_0000, 1'b1);
        send_word(32'hFFFF_FFFF, 1'b1);
    endtask

    task automatic test_random_directions();
        random_phase(DIR_U8_U32, 28);
        random_phase(DIR_U16_U32, 28);
        random_phase(DIR_U32_U16, 28);
        random_phase(DIR_U16_U8, 28);
        random_phase(DIR_U32_U8, 28);
        random_phase(DIR_U8_U16, 28);
    endtask

    // receiver holds off while four-unit code points keep coming
    task automatic test_backpressure();
        set_direction(DIR_U32_U8);
        idle_on = 1'b0;
        hold_cycles = 80;
        for (int k = 0; k < 12; k++) begin
            send_word($urandom_range(32'h10000, 32'h10FFFF), k == 11);
        end
        drain();
        idle_on = 1'b1;
    endtask

    task automatic test_steady_stream();
        idle_on = 1'b0;
        random_phase(DIR_U32_U16, 20);
        random_phase(DIR_U8_U16, 20);
    endtask

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = DIR_U8_U16;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tlast     = 1'b0;
        dir_q       = DIR_U8_U16;
        clear_stream();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed();
        test_random_directions();
        test_backpressure();
        test_steady_stream();
        drain();

        $display("summary: %0d source words in all six directions, %0d direction writes",
                 words_sent, cfg_writes);
        $display("summary: %0d results checked, %0d strings converted, %0d rejected",
                 results_seen, strings_ok, strings_bad);
        if (mismatches == 0) begin
            $display("utf_transcoder_core_tb: clean");
        end else begin
            $display("utf_transcoder_core_tb: errors");
        end
        $finish;
    end

endmodule
